// File: hw/rtl/rtp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the rectangular-to-polar converter.
// No dependencies; every other file in hw/rtl imports this package.
package rtp_pkg;

  localparam int IN_WIDTH_DEF     = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Fraction bits carried below the integer input in the CORDIC datapath.
  localparam int GUARD_BITS = 16;

  // Width of the signed angle accumulator in binary angle units (2^32 is a full turn).
  localparam int Z_W = 33;

  // 1/K, the inverse CORDIC gain, in Q30.
  localparam logic [29:0] INV_GAIN_Q30   = 30'd652032874;
  // 2*pi scaled by 2^13 (Q3.13) and by 2^16 extra fraction bits for rounding.
  localparam logic [31:0] TWO_PI_Q13_Q16 = 32'd3373259426;
  // One full turn in the two output scales: 2*pi in Q3.13 and 360 * 128.
  localparam logic [15:0] FULL_RAD_Q13   = 16'd51472;
  localparam logic [15:0] FULL_DEG_128   = 16'd46080;
  localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;

  // Rounding offsets for the scaling products.
  localparam logic [63:0] RAD_ROUND = 64'd1 << 47;
  localparam logic [47:0] DEG_ROUND = 48'd1 << 31;
  localparam logic [48:0] MAG_ROUND = 49'd1 << 29;

  // Sign and axis information of one input word, carried alongside the datapath.
  typedef struct packed {
    logic zero;
    logic dx_zero;
    logic dy_zero;
    logic dx_neg;
    logic dy_neg;
  } quad_t;

  // atan(2^-k) in binary angle units.
  function automatic logic [31:0] atan_bam(input logic [4:0] k);
    logic [31:0] r;
    case (k)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/rect_to_polar_converter_top.sv
`timescale 1ns / 1ps
// Top level of the rectangular-to-polar converter: input register, CORDIC pipeline and back end.
// Depends on rtp_pkg, rtp_cordic_stage and rtp_post.
//
//   channel | handshake            | word contents
//   --------+----------------------+----------------------------------------------
//   input   | in_valid / in_ready  | dx, dy (signed, IN_WIDTH bits)
//   output  | out_valid / out_ready| magnitude, angle_rad, angle_deg, zero_vector
//
// One word enters per clock when the output side keeps up; the pipeline is one
// input register, one register per CORDIC iteration, and three back-end stages
// (quadrant mapping, scaling products, rounding). Reset is synchronous and active
// high; it clears only the valid bits. Each stage holds its word while the next one
// is full and stalled, and an empty stage keeps taking words, so bubbles close up
// and nothing is dropped.
module rect_to_polar_converter_top #(
  parameter int IN_WIDTH     = rtp_pkg::IN_WIDTH_DEF,
  parameter int CORDIC_STEPS = rtp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [IN_WIDTH-1:0] dx,
  input  logic [IN_WIDTH-1:0] dy,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         magnitude,
  output logic [15:0]         angle_rad,
  output logic [15:0]         angle_deg,
  output logic                zero_vector
);
  import rtp_pkg::*;

  // The datapath holds |d| * 2^GUARD_BITS times the CORDIC gain with room to spare.
  localparam int XW = IN_WIDTH + GUARD_BITS + 3;

  // Chain signals between the pipeline stages; entry 0 is the input register.
  logic                  cv   [0:CORDIC_STEPS];
  logic                  cr   [0:CORDIC_STEPS];
  logic signed [XW-1:0]  cx   [0:CORDIC_STEPS];
  logic signed [XW-1:0]  cy   [0:CORDIC_STEPS];
  logic signed [Z_W-1:0] cz   [0:CORDIC_STEPS];
  quad_t                 cq   [0:CORDIC_STEPS];

  logic [IN_WIDTH:0]     ax;
  logic [IN_WIDTH:0]     ay;
  quad_t                 quad_next;

  // Absolute values: negating the sign-extended input gives an exact magnitude,
  // including the most negative code.
  assign ax = dx[IN_WIDTH-1] ? ((IN_WIDTH + 1)'(0) - {1'b1, dx}) : {1'b0, dx};
  assign ay = dy[IN_WIDTH-1] ? ((IN_WIDTH + 1)'(0) - {1'b1, dy}) : {1'b0, dy};

  always_comb begin
    quad_next.dx_zero = (dx == '0);
    quad_next.dy_zero = (dy == '0);
    quad_next.zero    = quad_next.dx_zero && quad_next.dy_zero;
    quad_next.dx_neg  = dx[IN_WIDTH-1];
    quad_next.dy_neg  = dy[IN_WIDTH-1];
  end

  assign in_ready = !cv[0] || cr[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (in_ready) begin
      cv[0] <= in_valid;
    end
  end

  // The vectoring iterations start on the first quadrant with a zero angle.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cx[0] <= $signed({2'b00, ax, {GUARD_BITS{1'b0}}});
      cy[0] <= $signed({2'b00, ay, {GUARD_BITS{1'b0}}});
      cz[0] <= '0;
      cq[0] <= quad_next;
    end
  end

  // One register stage per CORDIC iteration.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    rtp_cordic_stage #(
      .XW   (XW),
      .STEP (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .x_in      (cx[i]),
      .y_in      (cy[i]),
      .z_in      (cz[i]),
      .quad_in   (cq[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .x_out     (cx[i+1]),
      .y_out     (cy[i+1]),
      .z_out     (cz[i+1]),
      .quad_out  (cq[i+1])
    );
  end

  // The back end consumes x, the accumulated angle and the quadrant flags;
  // the residual y of the last iteration is not needed.
  rtp_post #(
    .XW (XW)
  ) u_post (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (cv[CORDIC_STEPS]),
    .in_ready    (cr[CORDIC_STEPS]),
    .x_in        (cx[CORDIC_STEPS]),
    .z_in        (cz[CORDIC_STEPS]),
    .quad_in     (cq[CORDIC_STEPS]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .magnitude   (magnitude),
    .angle_rad   (angle_rad),
    .angle_deg   (angle_deg),
    .zero_vector (zero_vector)
  );

endmodule

// File: hw/rtl/rtp_cordic_stage.sv
`timescale 1ns / 1ps
// One registered CORDIC vectoring iteration with its own valid bit and stall logic.
// Depends on rtp_pkg for the arctangent table and the quadrant struct.
module rtp_cordic_stage #(
  parameter int XW   = 35,
  parameter int STEP = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [XW-1:0]          x_in,
  input  logic signed [XW-1:0]          y_in,
  input  logic signed [rtp_pkg::Z_W-1:0] z_in,
  input  rtp_pkg::quad_t                quad_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [XW-1:0]          x_out,
  output logic signed [XW-1:0]          y_out,
  output logic signed [rtp_pkg::Z_W-1:0] z_out,
  output rtp_pkg::quad_t                quad_out
);
  import rtp_pkg::*;

  localparam logic [4:0] SHIFT = 5'(STEP);

  logic signed [XW-1:0]  x_sh;
  logic signed [XW-1:0]  y_sh;
  logic signed [Z_W-1:0] step_angle;
  logic signed [XW-1:0]  x_next;
  logic signed [XW-1:0]  y_next;
  logic signed [Z_W-1:0] z_next;

  assign x_sh       = x_in >>> SHIFT;
  assign y_sh       = y_in >>> SHIFT;
  assign step_angle = $signed({1'b0, atan_bam(SHIFT)});

  // Rotate toward the x axis: the sign of y picks the direction.
  always_comb begin
    if (!y_in[XW-1]) begin
      x_next = x_in + y_sh;
      y_next = y_in - x_sh;
      z_next = z_in + step_angle;
    end else begin
      x_next = x_in - y_sh;
      y_next = y_in + x_sh;
      z_next = z_in - step_angle;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
      quad_out <= quad_in;
    end
  end

endmodule

// File: hw/rtl/rtp_post.sv
`timescale 1ns / 1ps
// Three-stage back end: quadrant mapping, scaling products, then rounding and wrap.
// Depends on rtp_pkg for the scale constants and the quadrant struct.
module rtp_post #(
  parameter int XW = 35
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [XW-1:0]          x_in,
  input  logic signed [rtp_pkg::Z_W-1:0] z_in,
  input  rtp_pkg::quad_t                quad_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   magnitude,
  output logic [15:0]                   angle_rad,
  output logic [15:0]                   angle_deg,
  output logic                          zero_vector
);
  import rtp_pkg::*;

  // The magnitude saturates once x reaches 2^34, so only bits 33:0 enter the products.
  localparam int XE = (XW > 35) ? XW : 35;

  logic v1, v2;
  logic r1, r2, r3;

  // Stage 1 registers.
  logic [31:0] a1;
  logic [17:0] hi1;
  logic [15:0] lo1;
  logic        ovf1;
  logic        zero1;

  // Stage 2 registers.
  logic [63:0] prod_rad2;
  logic [47:0] prod_deg2;
  logic [47:0] prod_hi2;
  logic [45:0] prod_lo2;
  logic        ovf2;
  logic        zero2;

  logic [31:0]     theta;
  logic [31:0]     a_next;
  logic [XW-1:0]   x_bits;
  logic [XE-1:0]   xs;
  logic [63:0]     prod_rad_next;
  logic [47:0]     prod_deg_next;
  logic [47:0]     prod_hi_next;
  logic [45:0]     prod_lo_next;
  logic [64:0]     rad_sum;
  logic [48:0]     deg_sum;
  logic [48:0]     mag_sum;
  logic [15:0]     rad_val;
  logic [15:0]     deg_val;
  logic [18:0]     mag_val;
  logic [15:0]     magnitude_next;
  logic [15:0]     angle_rad_next;
  logic [15:0]     angle_deg_next;

  assign r3       = !out_valid || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  // Stage 1: clamp the first-quadrant angle and place it in its quadrant.
  always_comb begin
    if (z_in[Z_W-1]) begin
      theta = '0;
    end else if (z_in > $signed({1'b0, QUARTER_TURN})) begin
      theta = QUARTER_TURN;
    end else begin
      theta = z_in[31:0];
    end
    if (quad_in.dx_zero) begin
      a_next = quad_in.dy_neg ? (QUARTER_TURN + QUARTER_TURN + QUARTER_TURN) : QUARTER_TURN;
    end else if (quad_in.dy_zero) begin
      a_next = quad_in.dx_neg ? (QUARTER_TURN + QUARTER_TURN) : '0;
    end else if (!quad_in.dx_neg && !quad_in.dy_neg) begin
      a_next = theta;
    end else if (quad_in.dx_neg && !quad_in.dy_neg) begin
      a_next = (QUARTER_TURN + QUARTER_TURN) - theta;
    end else if (quad_in.dx_neg) begin
      a_next = (QUARTER_TURN + QUARTER_TURN) + theta;
    end else begin
      a_next = 32'd0 - theta;
    end
  end

  assign x_bits = x_in;
  assign xs     = x_in[XW-1] ? '0 : XE'(x_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && r1) begin
      a1    <= a_next;
      hi1   <= xs[33:16];
      lo1   <= xs[15:0];
      ovf1  <= |xs[XE-1:34];
      zero1 <= quad_in.zero;
    end
  end

  // Stage 2: the four scaling products, each at most 32 by 32 bits.
  assign prod_rad_next = 64'(a1) * 64'(TWO_PI_Q13_Q16);
  assign prod_deg_next = 48'(a1) * 48'(FULL_DEG_128);
  assign prod_hi_next  = 48'(hi1) * 48'(INV_GAIN_Q30);
  assign prod_lo_next  = 46'(lo1) * 46'(INV_GAIN_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && r2) begin
      prod_rad2 <= prod_rad_next;
      prod_deg2 <= prod_deg_next;
      prod_hi2  <= prod_hi_next;
      prod_lo2  <= prod_lo_next;
      ovf2      <= ovf1;
      zero2     <= zero1;
    end
  end

  // Stage 3: round, wrap a full turn to zero and saturate the magnitude.
  assign rad_sum = {1'b0, prod_rad2} + {1'b0, RAD_ROUND};
  assign deg_sum = {1'b0, prod_deg2} + {1'b0, DEG_ROUND};
  assign mag_sum = {1'b0, prod_hi2} + 49'(prod_lo2[45:16]) + MAG_ROUND;
  assign rad_val = rad_sum[63:48];
  assign deg_val = deg_sum[47:32];
  assign mag_val = mag_sum[48:30];

  always_comb begin
    if (zero2) begin
      magnitude_next = '0;
      angle_rad_next = '0;
      angle_deg_next = '0;
    end else begin
      magnitude_next = (ovf2 || (|mag_val[18:16])) ? 16'hFFFF : mag_val[15:0];
      angle_rad_next = (rad_val >= FULL_RAD_Q13) ? 16'd0 : rad_val;
      angle_deg_next = (deg_val >= FULL_DEG_128) ? 16'd0 : deg_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && r3) begin
      magnitude   <= magnitude_next;
      angle_rad   <= angle_rad_next;
      angle_deg   <= angle_deg_next;
      zero_vector <= zero2;
    end
  end

endmodule

// File: tb/sv/rect_to_polar_converter_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rect_to_polar_converter_top: directed and random displacement words.
// Depends only on the converter RTL; every polar word is predicted here and checked in order.
module rect_to_polar_converter_top_tb;

  localparam int IN_W        = 16;
  localparam int STEPS       = 16;
  // Pipeline depth of the converter: its input register, one register per CORDIC step and its back-end stages.
  localparam int LATENCY     = STEPS + 4;
  // Cycles without any accepted word before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  localparam int N_RANDOM    = 1600;

  // Fixed-point constants of the converter, in 64-bit form for the predictor.
  localparam longint unsigned QTURN            = 64'h4000_0000;
  localparam longint unsigned INV_K_Q30        = 64'd652032874;
  localparam longint unsigned TURN_RAD_Q13_Q16 = 64'd3373259426;
  localparam longint unsigned TURN_RAD_Q13     = 64'd51472;
  localparam longint unsigned TURN_DEG_128     = 64'd46080;

  // One displacement word waiting to be sent. The idle percentages set how often the
  // sender and the receiver hold back while this word is current. A word with hold set
  // is not offered until every earlier word has come back out of the converter.
  typedef struct {
    logic signed [IN_W-1:0] dx;
    logic signed [IN_W-1:0] dy;
    bit                     hold;
    int unsigned            tx_idle;
    int unsigned            rx_idle;
  } disp_word_t;

  typedef struct {
    logic [15:0] magnitude;
    logic [15:0] angle_rad;
    logic [15:0] angle_deg;
    logic        zero_vector;
  } polar_word_t;

  // An accepted input word together with the polar word it must produce.
  typedef struct {
    logic signed [IN_W-1:0] dx;
    logic signed [IN_W-1:0] dy;
    polar_word_t            polar;
  } polar_expect_t;

  // atan(2^-k) as a binary angle, where 2^32 is one full turn.
  longint atan_turns [0:31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  logic signed [IN_W-1:0] dx          = '0;
  logic signed [IN_W-1:0] dy          = '0;
  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  logic [15:0]            magnitude;
  logic [15:0]            angle_rad;
  logic [15:0]            angle_deg;
  logic                   zero_vector;

  disp_word_t    disp_q[$];
  polar_expect_t polar_q[$];

  // words_sent belongs to the driver, results_seen to the monitor (nonblocking), so each
  // side reads a stable value of the other's count.
  int unsigned words_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned idle_cycles  = 0;
  int unsigned fail_count   = 0;

  rect_to_polar_converter_top #(
    .IN_WIDTH    (IN_W),
    .CORDIC_STEPS(STEPS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .dx         (dx),
    .dy         (dy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .magnitude  (magnitude),
    .angle_rad  (angle_rad),
    .angle_deg  (angle_deg),
    .zero_vector(zero_vector)
  );

  always #5 clk = ~clk;

  // Predicts the polar word for one displacement. The heading is found by CORDIC
  // vectoring on the absolute values, clamped to the first quadrant, and then mapped to
  // the full circle by the signs of the inputs; axis directions bypass the CORDIC angle.
  function automatic polar_word_t polar_of(input logic signed [IN_W-1:0] px,
                                           input logic signed [IN_W-1:0] py);
    polar_word_t     r;
    longint          sx, sy, x, y, z, xo;
    longint unsigned theta, a, xs, p, mag, rad, deg;
    int              i;
    r.magnitude   = '0;
    r.angle_rad   = '0;
    r.angle_deg   = '0;
    r.zero_vector = 1'b0;
    sx = px;
    sy = py;
    if (sx == 0 && sy == 0) begin
      r.zero_vector = 1'b1;
      return r;
    end
    x = (sx < 0 ? -sx : sx) * 65536;
    y = (sy < 0 ? -sy : sy) * 65536;
    z = 0;
    for (i = 0; i < STEPS; i++) begin
      xo = x;
      if (y >= 0) begin
        x = x + (y >>> (i % 32));
        y = y - (xo >>> (i % 32));
        z = z + atan_turns[i % 32];
      end else begin
        x = x - (y >>> (i % 32));
        y = y + (xo >>> (i % 32));
        z = z - atan_turns[i % 32];
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(QTURN)) z = longint'(QTURN);
    theta = longint'(z);

    if (sx == 0) begin
      a = (sy > 0) ? QTURN : 3 * QTURN;
    end else if (sy == 0) begin
      a = (sx < 0) ? 2 * QTURN : 64'd0;
    end else if (sx > 0 && sy > 0) begin
      a = theta;
    end else if (sx < 0 && sy > 0) begin
      a = 2 * QTURN - theta;
    end else if (sx < 0) begin
      a = 2 * QTURN + theta;
    end else begin
      // Fourth quadrant; a first-quadrant angle of zero folds back to zero.
      a = (4 * QTURN - theta) & 64'hFFFF_FFFF;
    end

    // Gain correction of the final x, split to keep the product inside 64 bits.
    xs  = (x < 0) ? 64'd0 : longint'(x);
    p   = (xs >> 16) * INV_K_Q30 + (((xs & 64'hFFFF) * INV_K_Q30) >> 16);
    mag = (p + (64'd1 << 29)) >> 30;
    if (mag > 64'hFFFF) mag = 64'hFFFF;

    // Angles that round up to a full turn wrap to zero.
    rad = (a * TURN_RAD_Q13_Q16 + (64'd1 << 47)) >> 48;
    if (rad >= TURN_RAD_Q13) rad = 0;
    deg = (a * TURN_DEG_128 + (64'd1 << 31)) >> 32;
    if (deg >= TURN_DEG_128) deg = 0;

    r.magnitude = mag[15:0];
    r.angle_rad = rad[15:0];
    r.angle_deg = deg[15:0];
    return r;
  endfunction

  task automatic queue_word(input logic signed [IN_W-1:0] qx, input logic signed [IN_W-1:0] qy,
                            input bit hold, input int unsigned tx_idle,
                            input int unsigned rx_idle);
    disp_word_t w;
    w.dx      = qx;
    w.dy      = qy;
    w.hold    = hold;
    w.tx_idle = tx_idle;
    w.rx_idle = rx_idle;
    disp_q.push_back(w);
  endtask

  // Driver. When the current word is taken (or none is offered) the next one may be
  // presented; the payload only changes at that point, so a stalled word stays put.
  always @(posedge clk) begin : drive_proc
    polar_expect_t e;
    disp_word_t    w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        e.dx    = dx;
        e.dy    = dy;
        e.polar = polar_of(dx, dy);
        polar_q.push_back(e);
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (disp_q.size() != 0 && !(disp_q[0].hold && results_seen != words_sent) &&
            $urandom_range(99) >= disp_q[0].tx_idle) begin
          w = disp_q.pop_front();
          dx          <= w.dx;
          dy          <= w.dy;
          in_valid    <= 1'b1;
          rx_idle_pct <= w.rx_idle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each accepted polar word is compared with the oldest prediction; the ready
  // for the next cycle is drawn from the idle rate of the current phase.
  always @(posedge clk) begin : check_proc
    polar_expect_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (polar_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("ERROR: polar word with nothing pending: mag=%0d rad=%0d deg=%0d zero=%0b",
                     magnitude, angle_rad, angle_deg, zero_vector);
          end
        end else begin
          want = polar_q.pop_front();
          if (magnitude !== want.polar.magnitude || angle_rad !== want.polar.angle_rad ||
              angle_deg !== want.polar.angle_deg ||
              zero_vector !== want.polar.zero_vector) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("ERROR: dx=%0d dy=%0d expected mag=%0d rad=%0d deg=%0d zero=%0b",
                       want.dx, want.dy, want.polar.magnitude, want.polar.angle_rad,
                       want.polar.angle_deg, want.polar.zero_vector);
              $display("       actual   mag=%0d rad=%0d deg=%0d zero=%0b",
                       magnitude, angle_rad, angle_deg, zero_vector);
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: counts cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("rect_to_polar_converter_top test failed");
    $finish;
  end

  // Stimulus and end of run.
  initial begin : stim_proc
    logic signed [IN_W-1:0] rx, ry, v;
    int                     n, phase, kind;
    int unsigned            tx_pct, rx_pct;
    logic signed [IN_W-1:0] corner [0:6];
    corner = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFE, 16'sh7FFF};

    // Directed words: the zero vector, the four axis directions at unit and full scale,
    // the corners of the input range, the four unit diagonals, and headings just off the
    // axes, where +x approached from below rounds up to a full turn and wraps to zero.
    queue_word(16'sd0, 16'sd0, 1'b1, 37, 64);
    queue_word(16'sd1, 16'sd0, 1'b0, 37, 64);
    queue_word(-16'sd1, 16'sd0, 1'b0, 37, 64);
    queue_word(16'sd0, 16'sd1, 1'b0, 37, 64);
    queue_word(16'sd0, -16'sd1, 1'b0, 37, 64);
    queue_word(16'sh7FFF, 16'sd0, 1'b0, 37, 64);
    queue_word(16'sh8000, 16'sd0, 1'b0, 37, 64);
    queue_word(16'sd0, 16'sh7FFF, 1'b0, 37, 64);
    queue_word(16'sd0, 16'sh8000, 1'b0, 37, 64);
    queue_word(16'sh7FFF, 16'sh7FFF, 1'b0, 37, 64);
    queue_word(16'sh8000, 16'sh8000, 1'b0, 37, 64);
    queue_word(16'sh8000, 16'sh7FFF, 1'b0, 37, 64);
    queue_word(16'sh7FFF, 16'sh8000, 1'b0, 37, 64);
    queue_word(16'sd1, 16'sd1, 1'b0, 37, 64);
    queue_word(-16'sd1, 16'sd1, 1'b0, 37, 64);
    queue_word(-16'sd1, -16'sd1, 1'b0, 37, 64);
    queue_word(16'sd1, -16'sd1, 1'b0, 37, 64);
    queue_word(16'sh7FFF, -16'sd1, 1'b0, 37, 64);
    queue_word(16'sh7FFF, 16'sd1, 1'b0, 37, 64);
    queue_word(16'sh8000, -16'sd1, 1'b0, 37, 64);
    queue_word(16'sh8000, 16'sd1, 1'b0, 37, 64);
    queue_word(16'sd1, 16'sh8000, 1'b0, 37, 64);
    queue_word(-16'sd1, 16'sh7FFF, 1'b0, 37, 64);

    // Random words in three idling phases. The first word of each phase waits until the
    // converter has drained, so the pipeline also runs from empty under every phase.
    for (n = 0; n < N_RANDOM; n++) begin
      phase = n * 3 / N_RANDOM;
      case (phase)
        0:       begin tx_pct = 37; rx_pct = 64; end
        1:       begin tx_pct = 64; rx_pct = 37; end
        default: begin tx_pct = 0;  rx_pct = 0;  end
      endcase
      kind = $urandom_range(9);
      case (kind)
        5: begin
          // Short vectors, where rounding of the magnitude matters most.
          rx = 16'(int'($urandom_range(31)) - 16);
          ry = 16'(int'($urandom_range(31)) - 16);
        end
        6: begin
          // On an axis.
          v = 16'($urandom);
          if ($urandom_range(1)) begin rx = v; ry = '0; end
          else begin rx = '0; ry = v; end
        end
        7: begin
          // Just off an axis: one coordinate tiny, the other large.
          v  = 16'(int'($urandom_range(7)) - 4);
          rx = 16'($urandom);
          if ($urandom_range(1)) begin ry = v; end
          else begin ry = rx; rx = v; end
        end
        8: begin
          // On a diagonal, any quadrant.
          v  = 16'($urandom_range(32767));
          rx = $urandom_range(1) ? v : -v;
          ry = $urandom_range(1) ? v : -v;
        end
        9: begin
          rx = corner[$urandom_range(6)];
          ry = corner[$urandom_range(6)];
        end
        default: begin
          rx = 16'($urandom);
          ry = 16'($urandom);
        end
      endcase
      queue_word(rx, ry, (n * 3 % N_RANDOM) < 3, tx_pct, rx_pct);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Every word offered and taken, then every polar word back, then a short tail in
    // which nothing more may appear.
    while (disp_q.size() != 0 || in_valid) @(posedge clk);
    while (results_seen != words_sent) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    if (polar_q.size() != 0) begin
      $display("ERROR: %0d predicted polar words never arrived", polar_q.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("rect_to_polar_converter_top test passed");
    end else begin
      $display("rect_to_polar_converter_top test failed");
    end
    $finish;
  end

endmodule
